// ===== hw/rtl/vertex_transform_4x4_unit_assert.svh =====
// Assertion macros shared by the vertex transform RTL
`ifndef VERTEX_TRANSFORM_4X4_UNIT_ASSERT_SVH
`define VERTEX_TRANSFORM_4X4_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define VT4_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vt4 assertion failed");

// Next-cycle implication, disabled during reset
`define VT4_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vt4 assertion failed");

`endif

// ===== hw/rtl/vt4_pkg.sv =====
`default_nettype none
package vt4_pkg;

  localparam int WORD_BITS = 32;
  localparam int FIELD_W   = 32;
  localparam int ENT_W     = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_N     = 8;
  localparam int IDX_W     = 3;
  localparam int PROD_W    = 2 * ENT_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RND_W     = SUM_W - 16;
  localparam int LANE_LAT  = 3;
  // divider geometry
  localparam int QW        = WORD_BITS + 1;
  localparam int AW        = WORD_BITS + 18;
  localparam int BW        = WORD_BITS + 1;
  localparam int RW        = BW + 1;
  localparam int DIV_LAT   = QW + 2;
  localparam int LAT       = 1 + LANE_LAT + DIV_LAT;

  typedef enum logic [1:0] {
    OP_PRE_POINT  = 2'd0,
    OP_POST_POINT = 2'd1,
    OP_PRE_VEC4   = 2'd2,
    OP_POST_VEC4  = 2'd3
  } op_t;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_Q = (WORD_BITS > 17) ? word_t'(65536) : WMAX;

  localparam logic [CFG_W-1:0] CFG_RST [CFG_N] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  dz;
  } out_t;

  // Clamp a rounded sum to the word range
  function automatic word_t sat_word(input logic signed [RND_W-1:0] v);
    word_t r;
    if (v > $signed({{(RND_W-WORD_BITS){1'b0}}, WMAX})) begin
      r = WMAX;
    end else if (v < $signed({{(RND_W-WORD_BITS){1'b1}}, WMIN})) begin
      r = WMIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vt4_lane.sv =====
`default_nettype none
module vt4_lane import vt4_pkg::*; (
  input  wire logic                    clk,
  input  wire logic signed [ENT_W-1:0]   m [4],
  input  wire logic signed [FIELD_W-1:0] v [4],
  output word_t                        res
);

  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [PAIR_W-1:0] pair_r [2];
  logic signed [SUM_W-1:0]  sum_nxt;
  word_t                    res_r;

  // Multiply each entry by its component
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod_r[k] <= PROD_W'(m[k] * v[k]);
    end
  end

  // Add products in pairs
  always_ff @(posedge clk) begin
    pair_r[0] <= PAIR_W'(prod_r[0]) + PAIR_W'(prod_r[1]);
    pair_r[1] <= PAIR_W'(prod_r[2]) + PAIR_W'(prod_r[3]);
  end

  // Final add with half-LSB rounding
  always_comb begin
    sum_nxt = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]) + SUM_W'(32768);
  end

  always_ff @(posedge clk) begin
    res_r <= sat_word(sum_nxt[SUM_W-1:16]);
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/vt4_div.sv =====
`default_nettype none
module vt4_div import vt4_pkg::*; (
  input  wire logic  clk,
  input  wire word_t n,
  input  wire word_t d,
  output word_t      q_o
);

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
    logic          zero;
    logic          npos;
    logic          nneg;
  } dstage_t;

  dstage_t st_r   [QW+1];
  dstage_t st_nxt [QW+1];
  word_t   q_r;
  word_t   q_nxt;

  // Prepare magnitudes and step the restoring division one bit per stage
  always_comb begin
    logic [WORD_BITS-1:0] un;
    logic [WORD_BITS-1:0] ud;
    logic [RW-1:0]        sh;
    un = n[WORD_BITS-1] ? WORD_BITS'(-n) : WORD_BITS'(n);
    ud = d[WORD_BITS-1] ? WORD_BITS'(-d) : WORD_BITS'(d);
    st_nxt[0].a    = {1'b0, un, 17'b0} + AW'(ud);
    st_nxt[0].b    = {ud, 1'b0};
    st_nxt[0].ovf  = RW'(st_nxt[0].a[AW-1:QW]) >= RW'(st_nxt[0].b);
    st_nxt[0].rem  = RW'(st_nxt[0].a[AW-1:QW]);
    st_nxt[0].q    = '0;
    st_nxt[0].neg  = n[WORD_BITS-1] ^ d[WORD_BITS-1];
    st_nxt[0].zero = (d == '0);
    st_nxt[0].npos = !n[WORD_BITS-1] && (n != '0);
    st_nxt[0].nneg = n[WORD_BITS-1];
    for (int s = 1; s <= QW; s++) begin
      st_nxt[s] = st_r[s-1];
      sh = {st_r[s-1].rem[RW-2:0], st_r[s-1].a[QW-s]};
      if (sh >= RW'(st_r[s-1].b)) begin
        st_nxt[s].rem     = sh - RW'(st_r[s-1].b);
        st_nxt[s].q[QW-s] = 1'b1;
      end else begin
        st_nxt[s].rem = sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= QW; s++) begin
      st_r[s] <= st_nxt[s];
    end
  end

  // Apply sign, zero-divisor rule and saturation
  always_comb begin
    if (st_r[QW].zero) begin
      q_nxt = st_r[QW].npos ? WMAX : (st_r[QW].nneg ? WMIN : '0);
    end else if (!st_r[QW].neg) begin
      if (st_r[QW].ovf || (st_r[QW].q > QW'(WMAX))) begin
        q_nxt = WMAX;
      end else begin
        q_nxt = st_r[QW].q[WORD_BITS-1:0];
      end
    end else begin
      if (st_r[QW].ovf || (st_r[QW].q > (QW'(1) << (WORD_BITS-1)))) begin
        q_nxt = WMIN;
      end else begin
        q_nxt = -st_r[QW].q[WORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q_o = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/vt4_merge.sv =====
`default_nettype none
module vt4_merge import vt4_pkg::*; (
  input  wire logic  clk,
  input  wire logic  point,
  input  wire word_t r [4],
  output out_t       res
);

  typedef struct packed {
    logic  point;
    logic  dz;
    word_t x;
    word_t y;
    word_t z;
    word_t w;
  } byp_t;

  byp_t  byp_r [DIV_LAT];
  word_t qx, qy, qz;

  // Perspective divide of x, y and z by the fourth sum
  vt4_div u_div_x (.clk(clk), .n(r[0]), .d(r[3]), .q_o(qx));
  vt4_div u_div_y (.clk(clk), .n(r[1]), .d(r[3]), .q_o(qy));
  vt4_div u_div_z (.clk(clk), .n(r[2]), .d(r[3]), .q_o(qz));

  // Hold mode and raw sums alongside the dividers
  always_ff @(posedge clk) begin
    byp_r[0] <= '{point: point, dz: point && (r[3] == '0),
                  x: r[0], y: r[1], z: r[2], w: r[3]};
    for (int i = 1; i < DIV_LAT; i++) begin
      byp_r[i] <= byp_r[i-1];
    end
  end

  // Pick divided or raw results
  always_comb begin
    if (byp_r[DIV_LAT-1].point) begin
      res = '{x: qx, y: qy, z: qz, w: ONE_Q, dz: byp_r[DIV_LAT-1].dz};
    end else begin
      res = '{x: byp_r[DIV_LAT-1].x, y: byp_r[DIV_LAT-1].y,
              z: byp_r[DIV_LAT-1].z, w: byp_r[DIV_LAT-1].w, dz: 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vertex_transform_4x4_unit.sv =====
`default_nettype none
// Vertex transform by a 4x4 matrix, signed Q16.16.
// Request channel: raise start with in_op and in_x..in_w; the request is
// taken at any edge where start is high and busy is low. busy stays low,
// so one vertex may be issued every clock cycle.
// Result channel: out_valid pulses for one cycle with out_x..out_w and
// out_divide_by_zero; the receiver cannot stall, results are never held.
// Pipeline: the accepting edge loads the first of 39 register stages:
// one input register, the dot-product lane registers (multiply, pair
// add, final add with rounding) and the divide merge, which is a
// 33-stage restoring divider, one quotient bit per stage, plus a
// prepare and a saturate stage. Throughput is one vertex per cycle.
// Matrix: eight 64-bit registers written through cfg_we/cfg_idx/cfg_data;
// the user must write them only while no request is in flight, as the
// block does not enforce it. Synchronous reset (rst_n low) restores the
// identity matrix and drops all requests in flight.
module vertex_transform_4x4_unit import vt4_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_op,
  input  wire logic signed [FIELD_W-1:0] in_x,
  input  wire logic signed [FIELD_W-1:0] in_y,
  input  wire logic signed [FIELD_W-1:0] in_z,
  input  wire logic signed [FIELD_W-1:0] in_w,
  output logic                         out_valid,
  output logic signed [FIELD_W-1:0]    out_x,
  output logic signed [FIELD_W-1:0]    out_y,
  output logic signed [FIELD_W-1:0]    out_z,
  output logic signed [FIELD_W-1:0]    out_w,
  output logic                         out_divide_by_zero,
  input  wire logic                    cfg_we,
  input  wire logic [IDX_W-1:0]        cfg_idx,
  input  wire logic [CFG_W-1:0]        cfg_data
);

  logic [CFG_W-1:0]          cfg_r [CFG_N];
  logic                      acc;
  logic                      is_point;
  logic                      is_post;
  logic                      post_r;
  logic                      pt_r;
  logic                      pt_d_r [LANE_LAT];
  logic signed [FIELD_W-1:0] v_r [4];
  logic signed [ENT_W-1:0]   m [4][4];
  word_t                     lane_res [4];
  logic                      vld_r [LAT];
  out_t                      res;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign is_point = (op_t'(in_op) == OP_PRE_POINT) || (op_t'(in_op) == OP_POST_POINT);
  assign is_post  = (op_t'(in_op) == OP_POST_POINT) || (op_t'(in_op) == OP_POST_VEC4);

  // Matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_N; i++) begin
        cfg_r[i] <= CFG_RST[i];
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_data;
    end
  end

  // Capture the request; w is 1.0 in point modes
  always_ff @(posedge clk) begin
    post_r <= is_post;
    pt_r   <= is_point;
    v_r[0] <= in_x;
    v_r[1] <= in_y;
    v_r[2] <= in_z;
    v_r[3] <= is_point ? FIELD_W'(65536) : in_w;
  end

  // Route matrix entries to lanes: columns for pre, rows for post
  always_comb begin
    logic [1:0]       rr;
    logic [1:0]       cc;
    logic [CFG_W-1:0] word;
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        rr = post_r ? 2'(i) : 2'(k);
        cc = post_r ? 2'(k) : 2'(i);
        word = cfg_r[{rr, cc[1]}];
        m[i][k] = cc[0] ? word[CFG_W-1:ENT_W] : word[ENT_W-1:0];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    vt4_lane u_lane (.clk(clk), .m(m[g]), .v(v_r), .res(lane_res[g]));
  end

  // Carry the point flag beside the lanes
  always_ff @(posedge clk) begin
    pt_d_r[0] <= pt_r;
    for (int i = 1; i < LANE_LAT; i++) begin
      pt_d_r[i] <= pt_d_r[i-1];
    end
  end

  vt4_merge u_merge (
    .clk  (clk),
    .point(pt_d_r[LANE_LAT-1]),
    .r    (lane_res),
    .res  (res)
  );

  // Advance request valid through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= acc;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign out_valid          = vld_r[LAT-1];
  assign out_x              = FIELD_W'(res.x);
  assign out_y              = FIELD_W'(res.y);
  assign out_z              = FIELD_W'(res.z);
  assign out_w              = FIELD_W'(res.w);
  assign out_divide_by_zero = res.dz;

`include "vertex_transform_4x4_unit_assert.svh"

  // Every accepted request yields a result after the full latency
  `VT4_ASSERT_IMP(a_latency, clk, rst_n, acc, ##LAT out_valid)
  // A zero divisor saturates x to a rail or zero
  `VT4_ASSERT_IMP(a_dz_x, clk, rst_n, out_valid && out_divide_by_zero,
    (out_x == FIELD_W'(WMAX)) || (out_x == FIELD_W'(WMIN)) || (out_x == '0))
  // A flagged result comes from a point mode, so w is one
  `VT4_ASSERT_IMP(a_dz_w, clk, rst_n, out_valid && out_divide_by_zero,
    out_w == FIELD_W'(ONE_Q))

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import vt4_pkg::*; ();

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               dz;
  } vertex_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic out_divide_by_zero;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // matrix copy kept by the testbench
  logic [63:0] matrix_regs [8];
  vertex_res_t vertex_queue [$];
  int err_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;

  vertex_transform_4x4_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_w(out_w), .out_divide_by_zero(out_divide_by_zero),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint mat_entry(int r, int c);
    logic [63:0] reg_val;
    reg_val = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? longint'($signed(reg_val[63:32])) : longint'($signed(reg_val[31:0]));
  endfunction

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // exact sum of four products kept in 128 bits, rounded half up to Q16.16
  function automatic longint dot_round(longint a [4], longint b [4]);
    logic signed [127:0] acc;
    logic signed [127:0] rnd;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += 128'(a[i]) * 128'(b[i]);
    rnd = (acc + 128'sd32768) >>> 16;
    if (rnd > 128'sd2147483647) return 64'sd2147483647;
    if (rnd < -128'sd2147483648) return -64'sd2147483648;
    return longint'(rnd);
  endfunction

  // rounded perspective divide, ties away from zero
  function automatic longint persp_div(longint n, longint d);
    logic [127:0] un, ud, q;
    longint s;
    un = (n < 0) ? 128'(-n) : 128'(n);
    ud = (d < 0) ? 128'(-d) : 128'(d);
    q = ((un << 17) + ud) / (ud << 1);
    s = longint'(q);
    if ((n < 0) != (d < 0)) s = -s;
    return clamp_word(s);
  endfunction

  function automatic vertex_res_t transform_vertex(op_t op, logic signed [31:0] vx,
                                                   logic signed [31:0] vy,
                                                   logic signed [31:0] vz,
                                                   logic signed [31:0] vw);
    vertex_res_t res;
    longint vec [4];
    longint m [4];
    longint sums [4];
    longint den;
    bit post, point;
    post = op[0];
    point = !op[1];
    vec[0] = vx;
    vec[1] = vy;
    vec[2] = vz;
    vec[3] = point ? 64'sd65536 : longint'(vw);
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) m[k] = post ? mat_entry(i, k) : mat_entry(k, i);
      sums[i] = dot_round(m, vec);
    end
    res.dz = 1'b0;
    if (point) begin
      den = sums[3];
      for (int i = 0; i < 3; i++) begin
        if (den == 0)
          sums[i] = (sums[i] > 0) ? 64'sd2147483647 : ((sums[i] < 0) ? -64'sd2147483648 : 0);
        else
          sums[i] = persp_div(sums[i], den);
      end
      res.dz = (den == 0);
      sums[3] = 65536;
    end
    res.x = sums[0][31:0];
    res.y = sums[1][31:0];
    res.z = sums[2][31:0];
    res.w = sums[3][31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin
    vertex_res_t exp_res;
    if (rst_n && out_valid) begin
      if (vertex_queue.size() == 0) begin
        $display("result with no request outstanding");
        err_count++;
      end else begin
        exp_res = vertex_queue.pop_front();
        if (out_x !== exp_res.x) report_mismatch("out_x", out_x, exp_res.x);
        if (out_y !== exp_res.y) report_mismatch("out_y", out_y, exp_res.y);
        if (out_z !== exp_res.z) report_mismatch("out_z", out_z, exp_res.z);
        if (out_w !== exp_res.w) report_mismatch("out_w", out_w, exp_res.w);
        if (out_divide_by_zero !== exp_res.dz)
          report_mismatch("out_divide_by_zero", out_divide_by_zero, exp_res.dz);
      end
    end
  end

  // watchdog on cycles with no accepted request or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one request, holding start until accepted
  task automatic send_vertex(op_t op, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vz, logic [31:0] vw);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_x <= vx;
    in_y <= vy;
    in_z <= vz;
    in_w <= vw;
    @(posedge clk);
    while (busy) @(posedge clk);
    vertex_queue.push_back(transform_vertex(op, vx, vy, vz, vw));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one write cycle, then the write enable is driven low again
  task automatic write_matrix_reg(int idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx[IDX_W-1:0];
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    matrix_regs[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(262144)) - 131072);
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(196608)) - 98304);
      1: return rand_word();
      default: return 32'($signed($urandom_range(8192)) - 4096) <<< ($urandom_range(4) * 4);
    endcase
  endfunction

  // directed: identity, extremes, all ops, zero divisor
  task automatic test_directed();
    for (int o = 0; o < 4; o++) begin
      send_vertex(op_t'(o), 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0001_0000);
      send_vertex(op_t'(o), 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(op_t'(o), 32'hffff_ffff, 32'h0, 32'h1, 32'h0);
    end
    wait_drained();
    // w row zero: point modes divide by zero
    write_matrix_reg(6, 64'h0);
    write_matrix_reg(7, 64'h0);
    for (int o = 0; o < 4; o++) begin
      send_vertex(op_t'(o), 32'h0005_0000, 32'hfffb_0000, 32'h0, 32'h0003_0000);
      send_vertex(op_t'(o), 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
    end
    wait_drained();
    // extreme entries everywhere, then small divisor
    for (int i = 0; i < 8; i++) write_matrix_reg(i, 64'h8000_0000_7fff_ffff);
    for (int o = 0; o < 4; o++)
      send_vertex(op_t'(o), 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'h7fff_ffff);
    wait_drained();
    write_matrix_reg(7, 64'h0000_0001_0000_0000);
    write_matrix_reg(6, 64'h0);
    send_vertex(OP_PRE_POINT, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
    send_vertex(OP_POST_POINT, 32'hffff_8000, 32'h0, 32'h0, 32'h0);
    wait_drained();
  endtask

  // random matrices and vertices over the idling phases
  task automatic test_random(int n_items, int pct);
    idle_pct = pct;
    for (int i = 0; i < 8; i++) write_matrix_reg(i, {rand_entry(), rand_entry()});
    // sometimes make w row sparse so divides by zero come up
    if ($urandom_range(3) == 0) write_matrix_reg(6, 64'h0);
    for (int n = 0; n < n_items; n++) begin
      send_vertex(op_t'($urandom_range(3)), rand_word(), rand_word(), rand_word(), rand_word());
      if (n % 64 == 63 && $urandom_range(1)) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) matrix_regs[i] = CFG_RST[i];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 16; p++) test_random(64, (p % 4 == 0) ? 0 : ((p % 4 == 1) ? 46 :
                                                (p % 4 == 2) ? 0 : 28));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && vertex_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
